// File: rtl/text_to_lcd_glyph_stream_macros.svh
// assertion macros shared by the glyph stream rtl
// expects clk and rst in the scope where a macro is used
`ifndef TEXT_TO_LCD_GLYPH_STREAM_MACROS_SVH
`define TEXT_TO_LCD_GLYPH_STREAM_MACROS_SVH

// condition holds in the same cycle
`define TTLG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the next cycle
`define TTLG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ttlg_pkg.sv
// types, constants and the 6x8 font table for the glyph stream block
// no dependencies
package ttlg_pkg;

  localparam logic [7:0] CMD_COL     = 8'h80;
  localparam logic [7:0] CMD_ROW     = 8'h40;
  localparam logic [7:0] FIRST_CODE  = 8'd32;
  localparam int         ROM_ENTRIES = 101;
  localparam int         FONT_COLS   = 6;
  localparam int         MAX_DATA    = 6;
  localparam int         BEAT_W      = 3;
  localparam logic [BEAT_W-1:0] BEAT_COL = 3'd0;
  localparam logic [BEAT_W-1:0] BEAT_ROW = 3'd1;
  localparam logic [BEAT_W-1:0] BEAT_DATA0 = 3'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       new_string;
    logic [3:0] start_col;
    logic [2:0] start_row;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } out_t;

  // one classified character, ready for the back end
  typedef struct packed {
    logic [7:0] col_cmd;
    logic [7:0] row_cmd;
    logic [6:0] glyph_idx;
    logic       blank;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // first column in the top byte
  function automatic logic [47:0] font_row(input logic [6:0] idx);
    logic [47:0] r;
    case (idx)
      7'd0:   r = 48'h000000000000;
      7'd1:   r = 48'h0000004F0000;
      7'd2:   r = 48'h000007000700;
      7'd3:   r = 48'h00147F147F14;
      7'd4:   r = 48'h00242A7F2A12;
      7'd5:   r = 48'h002313086462;
      7'd6:   r = 48'h003649552250;
      7'd7:   r = 48'h000005030000;
      7'd8:   r = 48'h00001C224100;
      7'd9:   r = 48'h000041221C00;
      7'd10:  r = 48'h0014083E0814;
      7'd11:  r = 48'h0008083E0808;
      7'd12:  r = 48'h000050300000;
      7'd13:  r = 48'h000808080808;
      7'd14:  r = 48'h000060600000;
      7'd15:  r = 48'h002010080402;
      7'd16:  r = 48'h003E5149453E;
      7'd17:  r = 48'h0000427F4000;
      7'd18:  r = 48'h004261514946;
      7'd19:  r = 48'h002141454B31;
      7'd20:  r = 48'h001814127F10;
      7'd21:  r = 48'h002745454539;
      7'd22:  r = 48'h003C4A494930;
      7'd23:  r = 48'h000171090503;
      7'd24:  r = 48'h003649494936;
      7'd25:  r = 48'h00064949291E;
      7'd26:  r = 48'h000036360000;
      7'd27:  r = 48'h000056360000;
      7'd28:  r = 48'h000814224100;
      7'd29:  r = 48'h001414141414;
      7'd30:  r = 48'h000041221408;
      7'd31:  r = 48'h000201510906;
      7'd32:  r = 48'h00324979413E;
      7'd33:  r = 48'h007E1111117E;
      7'd34:  r = 48'h007F4949493E;
      7'd35:  r = 48'h003E41414122;
      7'd36:  r = 48'h007F4141221C;
      7'd37:  r = 48'h007F49494941;
      7'd38:  r = 48'h007F09090901;
      7'd39:  r = 48'h003E4149497A;
      7'd40:  r = 48'h007F0808087F;
      7'd41:  r = 48'h0000417F4100;
      7'd42:  r = 48'h002040413F01;
      7'd43:  r = 48'h007F08142241;
      7'd44:  r = 48'h007F40404040;
      7'd45:  r = 48'h007F0204027F;
      7'd46:  r = 48'h007F0408107F;
      7'd47:  r = 48'h003E4141413E;
      7'd48:  r = 48'h007F09090906;
      7'd49:  r = 48'h003E4151215E;
      7'd50:  r = 48'h007F09192946;
      7'd51:  r = 48'h004649494931;
      7'd52:  r = 48'h0001017F0101;
      7'd53:  r = 48'h003F4040403F;
      7'd54:  r = 48'h001F2040201F;
      7'd55:  r = 48'h003F4038403F;
      7'd56:  r = 48'h006314081463;
      7'd57:  r = 48'h000304780403;
      7'd58:  r = 48'h006151494543;
      7'd59:  r = 48'h00007F414100;
      7'd60:  r = 48'h0015167C1615;
      7'd61:  r = 48'h000041417F00;
      7'd62:  r = 48'h000402010204;
      7'd63:  r = 48'h004040404040;
      7'd64:  r = 48'h000001020400;
      7'd65:  r = 48'h002054545478;
      7'd66:  r = 48'h007F48444438;
      7'd67:  r = 48'h003844444420;
      7'd68:  r = 48'h00384444487F;
      7'd69:  r = 48'h003854545418;
      7'd70:  r = 48'h00087E090102;
      7'd71:  r = 48'h000C5252523E;
      7'd72:  r = 48'h007F08040478;
      7'd73:  r = 48'h0000447D4000;
      7'd74:  r = 48'h002040443D00;
      7'd75:  r = 48'h007F10284400;
      7'd76:  r = 48'h0000417F4000;
      7'd77:  r = 48'h007E020C027C;
      7'd78:  r = 48'h007E0402027C;
      7'd79:  r = 48'h003844444438;
      7'd80:  r = 48'h007C14141408;
      7'd81:  r = 48'h00081414187C;
      7'd82:  r = 48'h007C08040408;
      7'd83:  r = 48'h004854545420;
      7'd84:  r = 48'h00043F444020;
      7'd85:  r = 48'h003C4040207C;
      7'd86:  r = 48'h001C2040201C;
      7'd87:  r = 48'h003C4030403C;
      7'd88:  r = 48'h004428102844;
      7'd89:  r = 48'h000C5050503C;
      7'd90:  r = 48'h004464544C44;
      7'd91:  r = 48'h000008364100;
      7'd92:  r = 48'h0000007F0000;
      7'd93:  r = 48'h000041360800;
      7'd94:  r = 48'h000804081008;
      7'd95:  r = 48'h0008082A1C08;
      7'd96:  r = 48'h00081C2A0808;
      7'd97:  r = 48'h0004027F0204;
      7'd98:  r = 48'h0010207F2010;
      7'd99:  r = 48'h001C2A322A1C;
      7'd100: r = 48'h001C2244221C;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/ttlg_front.sv
// front end: accepts characters, keeps the text cursor, classifies the glyph
// depends on ttlg_pkg
module ttlg_front import ttlg_pkg::*; #(
  parameter int GLYPH_WIDTH  = 6,
  parameter int TEXT_COLUMNS = 14,
  parameter int TEXT_ROWS    = 6,
  parameter int GLYPH_COUNT  = 101
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  in_t     in_data,
  input  q_stat_t stat,
  output logic    push,
  output job_t    job
);

  logic [3:0] cursor_col, cursor_col_next;
  logic [2:0] cursor_row, cursor_row_next;
  logic [3:0] col_eff, col_inc;
  logic [2:0] row_eff, row_inc;
  logic [7:0] idx;
  logic       wrap;

  assign in_ready = !stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    col_eff = in_data.new_string ? in_data.start_col : cursor_col;
    row_eff = in_data.new_string ? in_data.start_row : cursor_row;
    idx     = in_data.char_code - FIRST_CODE;

    job.col_cmd   = CMD_COL | 8'(32'(col_eff) * GLYPH_WIDTH);
    job.row_cmd   = CMD_ROW | {5'b0, row_eff};
    job.glyph_idx = idx[6:0];
    job.blank     = (in_data.char_code < FIRST_CODE) || (32'(idx) >= GLYPH_COUNT) ||
                    (32'(idx) >= ROM_ENTRIES);

    // advance with wrap at the edges of the text grid
    col_inc = col_eff + 4'd1;
    wrap    = (32'(col_inc) >= TEXT_COLUMNS) || (col_inc == 4'd0);
    cursor_col_next = wrap ? 4'd0 : col_inc;
    row_inc = wrap ? row_eff + 3'd1 : row_eff;
    cursor_row_next = (32'(row_inc) >= TEXT_ROWS) ? 3'd0 : row_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (push) begin
      cursor_col <= cursor_col_next;
      cursor_row <= cursor_row_next;
    end
  end

endmodule

// File: rtl/ttlg_queue.sv
// two-entry job queue between the front and back ends
// depends on ttlg_pkg and the assertion macro header
`include "text_to_lcd_glyph_stream_macros.svh"
module ttlg_queue import ttlg_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head       = entry[rd_ptr];
  assign stat.full  = (count == 2'd2);
  assign stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `TTLG_ASSERT_NOW(a_count_range, 1'b1, count <= 2'd2, "queue count out of range")
  `TTLG_ASSERT_NOW(a_no_pop_empty, pop, !stat.empty, "queue popped while empty")
  `TTLG_ASSERT_NOW(a_no_push_full, push, !stat.full, "queue pushed while full")
  `TTLG_ASSERT_NEXT(a_fill, push && !pop, count == $past(count) + 2'd1, "queue count slipped")

endmodule

// File: rtl/ttlg_back.sv
// back end: steps through the command and data bytes of each queued character
// depends on ttlg_pkg and the assertion macro header
`include "text_to_lcd_glyph_stream_macros.svh"
module ttlg_back import ttlg_pkg::*; #(
  parameter int GLYPH_WIDTH = 6
) (
  input  logic    clk,
  input  logic    rst,
  input  q_stat_t stat,
  input  job_t    head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output out_t    out_data
);

  localparam int NDATA = (GLYPH_WIDTH > MAX_DATA) ? MAX_DATA : GLYPH_WIDTH;
  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(NDATA + 1);

  logic [BEAT_W-1:0] beat;
  logic [BEAT_W-1:0] col_idx;
  logic [47:0]       glyph;
  logic              advance;
  logic              fire;
  out_t              beat_out;

  assign advance = !out_valid || out_ready;
  assign fire    = advance && !stat.empty;
  assign pop     = fire && (beat == LAST_BEAT);

  always_comb begin
    col_idx = beat - BEAT_DATA0;
    glyph   = font_row(head.glyph_idx);
    beat_out.last = (beat == LAST_BEAT);
    case (beat)
      BEAT_COL: begin
        beat_out.out_byte = head.col_cmd;
        beat_out.is_data  = 1'b0;
      end
      BEAT_ROW: begin
        beat_out.out_byte = head.row_cmd;
        beat_out.is_data  = 1'b0;
      end
      default: begin
        beat_out.is_data = 1'b1;
        if (head.blank || (32'(col_idx) >= FONT_COLS)) begin
          beat_out.out_byte = '0;
        end else begin
          beat_out.out_byte = glyph[(FONT_COLS - 1 - 32'(col_idx)) * 8 +: 8];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat      <= BEAT_COL;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= !stat.empty;
      end
      if (fire) begin
        beat <= (beat == LAST_BEAT) ? BEAT_COL : beat + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= beat_out;
    end
  end

  `TTLG_ASSERT_NOW(a_beat_range, 1'b1, beat <= LAST_BEAT, "beat counter overran")
  `TTLG_ASSERT_NEXT(a_pop_last, pop, out_valid && out_data.last, "pop without a last byte")
  `TTLG_ASSERT_NEXT(a_cmd_first, fire && (beat == BEAT_COL),
                    out_valid && !out_data.is_data && !out_data.last,
                    "column command not a plain command byte")

endmodule

// File: rtl/text_to_lcd_glyph_stream.sv
// top level of the text to lcd glyph byte stream renderer
// depends on ttlg_pkg, ttlg_front, ttlg_queue and ttlg_back
//
// Each accepted character item produces bytes (eight by default) for an
// 84x48 lcd controller: a column address command, a row address command
// and the glyph columns of a 6x8 font (codes 32 to 132; other codes are blank).
// new_string loads the text cursor from start_col and start_row before the
// character; the cursor then steps on, wrapping at the grid edges. The back
// end sends one byte per cycle unless out_ready stalls it or the queue is
// empty, and each character gives two commands plus min(GLYPH_WIDTH, 6) data
// bytes; a two-entry queue lets the front take up to two characters ahead of
// the byte stream; bytes are registered at the output from the queue head.
module text_to_lcd_glyph_stream import ttlg_pkg::*; #(
  parameter int GLYPH_WIDTH  = 6,
  parameter int TEXT_COLUMNS = 14,
  parameter int TEXT_ROWS    = 6,
  parameter int GLYPH_COUNT  = 101
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  q_stat_t stat;
  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head;

  ttlg_front #(
    .GLYPH_WIDTH  (GLYPH_WIDTH),
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .push     (push),
    .job      (push_job)
  );

  ttlg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  ttlg_back #(
    .GLYPH_WIDTH (GLYPH_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
